>>> hdl/ebalu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the 8-bit CPU ALU.
// Used by ebalu_exec and eight_bit_cpu_alu_core; depends on nothing.
package ebalu_pkg;

  // Operation codes carried on cmd_i.
  typedef enum logic [5:0] {
    CMD_ADD   = 6'd0,
    CMD_ADC   = 6'd1,
    CMD_SUB   = 6'd2,
    CMD_SBC   = 6'd3,
    CMD_AND   = 6'd4,
    CMD_OR    = 6'd5,
    CMD_XOR   = 6'd6,
    CMD_CP    = 6'd7,
    CMD_INC8  = 6'd8,
    CMD_DEC8  = 6'd9,
    CMD_ADD16 = 6'd10,
    CMD_ADDSP = 6'd11,
    CMD_INC16 = 6'd12,
    CMD_DEC16 = 6'd13,
    CMD_RLCA  = 6'd14,
    CMD_RLA   = 6'd15,
    CMD_RRCA  = 6'd16,
    CMD_RRA   = 6'd17,
    CMD_DAA   = 6'd18,
    CMD_CPL   = 6'd19,
    CMD_CCF   = 6'd20,
    CMD_SCF   = 6'd21,
    CMD_RLC   = 6'd22,
    CMD_RRC   = 6'd23,
    CMD_RL    = 6'd24,
    CMD_RR    = 6'd25,
    CMD_SLA   = 6'd26,
    CMD_SRA   = 6'd27,
    CMD_SWAP  = 6'd28,
    CMD_SRL   = 6'd29,
    CMD_BIT   = 6'd30,
    CMD_RES   = 6'd31,
    CMD_SET   = 6'd32
  } cmd_e;

  // Decimal adjust thresholds and corrections.
  localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
  localparam logic [3:0] DAA_LO_LIMIT = 4'h9;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;

  // Flag nibble: bit 3 Z, bit 2 N, bit 1 H, bit 0 C.
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

  // One request as it enters the execute logic.
  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    flags_t      flags;
    logic [2:0]  bit_number;
  } op_t;

  // One result as it leaves the execute logic.
  typedef struct packed {
    logic [15:0] value;
    flags_t      flags;
    logic        write_back;
  } res_t;

endpackage

>>> hdl/eight_bit_cpu_alu_core.sv
`timescale 1ns / 1ps
// An accepted request is held in the input register, goes through the combinational execute
// logic and is then registered in the result register, which drives the output port.
// Throughput: one request per cycle while results are taken. The input register and the
// result register each hold one request; the input stalls only when both are full and
// the output is held.
// Reset (rst_ni, asynchronous, active low) empties both registers; no other state.
// Depends on ebalu_pkg and ebalu_exec.
module eight_bit_cpu_alu_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  cmd_i,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  input  logic [3:0]  flags_in_i,
  input  logic [2:0]  bit_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] result_value_o,
  output logic [3:0]  flags_out_o,
  output logic        write_back_o
);
  import ebalu_pkg::*;

  op_t  op_d;
  op_t  op_q;
  logic op_valid_q;
  res_t res_d;
  res_t res_q;
  logic res_valid_q;
  logic out_adv;
  logic in_acc;

  // The result register frees up when it is empty or being taken.
  assign out_adv    = !res_valid_q || !out_stall_i;
  assign in_stall_o = op_valid_q && !out_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign op_d.cmd        = cmd_e'(cmd_i);
  assign op_d.operand_a  = operand_a_i;
  assign op_d.operand_b  = operand_b_i;
  assign op_d.flags      = flags_t'(flags_in_i);
  assign op_d.bit_number = bit_number_i;

  // Execute logic between the input register and the result register.
  ebalu_exec u_exec (
    .op_i  (op_q),
    .res_o (res_d)
  );

  // Input register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      op_valid_q <= in_valid_i;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= op_d;
    end
  end

  // Result register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_adv) begin
      res_valid_q <= op_valid_q;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (out_adv && op_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = res_valid_q;
  assign result_value_o = res_q.value;
  assign flags_out_o    = res_q.flags;
  assign write_back_o   = res_q.write_back;

`ifndef SYNTHESIS
  // The input only stalls when both registers are full and the output is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (op_valid_q && res_valid_q && out_stall_i))
    else $error("input stalled without a full pipeline");

  // An accepted request is held in the input register on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> op_valid_q)
    else $error("accepted request lost");

  // A request that moves on reaches the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_q && out_adv) |=> res_valid_q)
    else $error("request dropped between registers");

  // Results that are not written always carry a zero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.write_back) |-> (res_q.value == 16'h0000))
    else $error("non-written result carries a value");
`endif

endmodule

>>> hdl/ebalu_exec.sv
`timescale 1ns / 1ps
// Combinational execute logic of the 8-bit CPU ALU: one request in, one result out.
// Depends on ebalu_pkg for the operation codes and the request and result types.
module ebalu_exec (
  input  ebalu_pkg::op_t  op_i,
  output ebalu_pkg::res_t res_o
);
  import ebalu_pkg::*;

  logic [7:0]  a;
  logic [7:0]  b;
  logic [15:0] a16;
  logic [15:0] b16;
  logic        cin;
  logic        cy;
  logic [8:0]  sum9;
  logic [4:0]  sum_lo;
  logic [8:0]  dif9;
  logic [4:0]  dif_lo;
  logic [16:0] add16;
  logic [12:0] add16_lo;
  logic [15:0] sp_sum;
  logic [4:0]  sp_lo;
  logic [8:0]  sp_byte;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_val;
  logic [7:0]  bit_mask;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic        use16;
  flags_t      nf;
  logic        wb;

  assign a   = op_i.operand_a[7:0];
  assign b   = op_i.operand_b[7:0];
  assign a16 = op_i.operand_a;
  assign b16 = op_i.operand_b;
  assign cin = op_i.flags.c;

  // Carry in only for the with-carry forms.
  assign cy = ((op_i.cmd == CMD_ADC) || (op_i.cmd == CMD_SBC)) ? cin : 1'b0;

  // 8-bit adder and subtractor with nibble carries; bit 8 or 4 is carry or borrow.
  assign sum9   = {1'b0, a} + {1'b0, b} + {8'd0, cy};
  assign sum_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cy};
  assign dif9   = {1'b0, a} - {1'b0, b} - {8'd0, cy};
  assign dif_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cy};

  // 16-bit add with half carry out of bit 11.
  assign add16    = {1'b0, a16} + {1'b0, b16};
  assign add16_lo = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};

  // Stack pointer plus signed byte; flags come from the unsigned low byte.
  assign sp_sum  = a16 + {{8{b[7]}}, b};
  assign sp_lo   = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
  assign sp_byte = {1'b0, a16[7:0]} + {1'b0, b};

  // Decimal adjust, decided on the value before adjustment.
  assign daa_lo  = op_i.flags.h || (a[3:0] > DAA_LO_LIMIT);
  assign daa_hi  = cin || (a > DAA_HI_LIMIT);
  assign daa_val = op_i.flags.n
                 ? (a - (cin ? DAA_HI_ADJ : 8'h00) - (op_i.flags.h ? DAA_LO_ADJ : 8'h00))
                 : (a + (daa_hi ? DAA_HI_ADJ : 8'h00) + (daa_lo ? DAA_LO_ADJ : 8'h00));

  assign bit_mask = 8'h01 << op_i.bit_number;

  // Operation select.
  always_comb begin
    r8    = 8'h00;
    r16   = 16'h0000;
    use16 = 1'b0;
    nf    = op_i.flags;
    wb    = 1'b1;
    case (op_i.cmd)
      CMD_ADD, CMD_ADC: begin
        r8 = sum9[7:0];
        nf = '{z: (sum9[7:0] == 8'h00), n: 1'b0, h: sum_lo[4], c: sum9[8]};
      end
      CMD_SUB, CMD_SBC: begin
        r8 = dif9[7:0];
        nf = '{z: (dif9[7:0] == 8'h00), n: 1'b1, h: dif_lo[4], c: dif9[8]};
      end
      CMD_CP: begin
        wb = 1'b0;
        nf = '{z: (dif9[7:0] == 8'h00), n: 1'b1, h: dif_lo[4], c: dif9[8]};
      end
      CMD_AND: begin
        r8 = a & b;
        nf = '{z: ((a & b) == 8'h00), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      CMD_OR: begin
        r8 = a | b;
        nf = '{z: ((a | b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_XOR: begin
        r8 = a ^ b;
        nf = '{z: ((a ^ b) == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_INC8: begin
        r8 = a + 8'h01;
        nf = '{z: (a == 8'hFF), n: 1'b0, h: (a[3:0] == 4'hF), c: cin};
      end
      CMD_DEC8: begin
        r8 = a - 8'h01;
        nf = '{z: (a == 8'h01), n: 1'b1, h: (a[3:0] == 4'h0), c: cin};
      end
      CMD_ADD16: begin
        use16 = 1'b1;
        r16   = add16[15:0];
        nf    = '{z: op_i.flags.z, n: 1'b0, h: add16_lo[12], c: add16[16]};
      end
      CMD_ADDSP: begin
        use16 = 1'b1;
        r16   = sp_sum;
        nf    = '{z: 1'b0, n: 1'b0, h: sp_lo[4], c: sp_byte[8]};
      end
      CMD_INC16: begin
        use16 = 1'b1;
        r16   = a16 + 16'h0001;
      end
      CMD_DEC16: begin
        use16 = 1'b1;
        r16   = a16 - 16'h0001;
      end
      CMD_RLCA, CMD_RLC: begin
        r8 = {a[6:0], a[7]};
        nf = '{z: (op_i.cmd == CMD_RLC) && (a == 8'h00), n: 1'b0, h: 1'b0, c: a[7]};
      end
      CMD_RLA, CMD_RL: begin
        r8 = {a[6:0], cin};
        nf = '{z: (op_i.cmd == CMD_RL) && ({a[6:0], cin} == 8'h00), n: 1'b0, h: 1'b0,
               c: a[7]};
      end
      CMD_RRCA, CMD_RRC: begin
        r8 = {a[0], a[7:1]};
        nf = '{z: (op_i.cmd == CMD_RRC) && (a == 8'h00), n: 1'b0, h: 1'b0, c: a[0]};
      end
      CMD_RRA, CMD_RR: begin
        r8 = {cin, a[7:1]};
        nf = '{z: (op_i.cmd == CMD_RR) && ({cin, a[7:1]} == 8'h00), n: 1'b0, h: 1'b0,
               c: a[0]};
      end
      CMD_DAA: begin
        r8 = daa_val;
        nf = '{z: (daa_val == 8'h00), n: op_i.flags.n, h: 1'b0,
               c: op_i.flags.n ? cin : daa_hi};
      end
      CMD_CPL: begin
        r8 = ~a;
        nf = '{z: op_i.flags.z, n: 1'b1, h: 1'b1, c: cin};
      end
      CMD_CCF: begin
        wb = 1'b0;
        nf = '{z: op_i.flags.z, n: 1'b0, h: 1'b0, c: ~cin};
      end
      CMD_SCF: begin
        wb = 1'b0;
        nf = '{z: op_i.flags.z, n: 1'b0, h: 1'b0, c: 1'b1};
      end
      CMD_SLA: begin
        r8 = {a[6:0], 1'b0};
        nf = '{z: (a[6:0] == 7'd0), n: 1'b0, h: 1'b0, c: a[7]};
      end
      CMD_SRA: begin
        r8 = {a[7], a[7:1]};
        nf = '{z: (a[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      CMD_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        nf = '{z: (a == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      CMD_SRL: begin
        r8 = {1'b0, a[7:1]};
        nf = '{z: (a[7:1] == 7'd0), n: 1'b0, h: 1'b0, c: a[0]};
      end
      CMD_BIT: begin
        wb = 1'b0;
        nf = '{z: ((a & bit_mask) == 8'h00), n: 1'b0, h: 1'b1, c: cin};
      end
      CMD_RES: begin
        r8 = a & ~bit_mask;
      end
      CMD_SET: begin
        r8 = a | bit_mask;
      end
      default: begin
        // Unused codes change nothing and write nothing.
        wb = 1'b0;
        nf = op_i.flags;
      end
    endcase
  end

  assign res_o.value      = use16 ? r16 : {8'h00, r8};
  assign res_o.flags      = nf;
  assign res_o.write_back = wb;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for eight_bit_cpu_alu_core. It predicts every request in a
// small scoreboard class, drives requests from a plain task and result stalls from an initial block.
// Depends on ebalu_pkg and the RTL of eight_bit_cpu_alu_core.
module testbench;
  import ebalu_pkg::*;

  localparam int unsigned RANDOM_REQUESTS = 1250;
  localparam int unsigned IDLE_PERCENT    = 35;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam logic [5:0]  CMD_FIRST_UNUSED = 6'd33;
  localparam logic [5:0]  CMD_LAST_UNUSED  = 6'd63;

  // One predicted or observed result.
  typedef struct packed {
    logic [15:0] value;
    logic [3:0]  flags;
    logic        write_back;
  } alu_out_t;

  // Holds the predicted results in request order and compares the block's results.
  class alu_check;
    alu_out_t    pending_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Works out what the ALU returns for one request; flags are {Z, N, H, C}.
    static function alu_out_t alu_predict(logic [5:0] cmd, logic [15:0] a16, logic [15:0] b16,
                                          logic [3:0] f, logic [2:0] bn);
      alu_out_t   res;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] r8;
      logic       cin;
      logic       t;
      logic       cout;
      logic [8:0] s9;
      logic [4:0] s5;
      logic [12:0] s13;
      logic [16:0] s17;
      a = a16[7:0];
      b = b16[7:0];
      cin = f[0];
      res.value = '0;
      res.flags = f;
      res.write_back = 1'b1;
      case (cmd)
        CMD_ADD, CMD_ADC: begin
          t = (cmd == CMD_ADC) ? cin : 1'b0;
          s9 = {1'b0, a} + {1'b0, b} + {8'h00, t};
          s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
          res.value = {8'h00, s9[7:0]};
          res.flags = {s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]};
        end
        CMD_SUB, CMD_SBC, CMD_CP: begin
          // A negative difference shows up as the sign bit of the wider result.
          t = (cmd == CMD_SBC) ? cin : 1'b0;
          s9 = {1'b0, a} - {1'b0, b} - {8'h00, t};
          s5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
          res.value = {8'h00, s9[7:0]};
          res.flags = {s9[7:0] == 8'h00, 1'b1, s5[4], s9[8]};
          if (cmd == CMD_CP) begin
            res.value = '0;
            res.write_back = 1'b0;
          end
        end
        CMD_AND: begin
          r8 = a & b;
          res.value = {8'h00, r8};
          res.flags = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
        end
        CMD_OR, CMD_XOR: begin
          r8 = (cmd == CMD_OR) ? (a | b) : (a ^ b);
          res.value = {8'h00, r8};
          res.flags = {r8 == 8'h00, 3'b000};
        end
        CMD_INC8: begin
          r8 = a + 8'd1;
          res.value = {8'h00, r8};
          res.flags = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
        end
        CMD_DEC8: begin
          r8 = a - 8'd1;
          res.value = {8'h00, r8};
          res.flags = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
        end
        CMD_ADD16: begin
          // Half carry comes out of bit 11; Z is kept.
          s17 = {1'b0, a16} + {1'b0, b16};
          s13 = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
          res.value = s17[15:0];
          res.flags = {f[3], 1'b0, s13[12], s17[16]};
        end
        CMD_ADDSP: begin
          // Sign-extended offset; H and C come from the unsigned low nibble and byte.
          s5 = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
          s9 = {1'b0, a16[7:0]} + {1'b0, b};
          res.value = a16 + {{8{b[7]}}, b};
          res.flags = {2'b00, s5[4], s9[8]};
        end
        CMD_INC16: res.value = a16 + 16'd1;
        CMD_DEC16: res.value = a16 - 16'd1;
        CMD_RLCA, CMD_RLC: begin
          r8 = {a[6:0], a[7]};
          res.value = {8'h00, r8};
          res.flags = {cmd == CMD_RLC && r8 == 8'h00, 2'b00, a[7]};
        end
        CMD_RLA, CMD_RL: begin
          r8 = {a[6:0], cin};
          res.value = {8'h00, r8};
          res.flags = {cmd == CMD_RL && r8 == 8'h00, 2'b00, a[7]};
        end
        CMD_RRCA, CMD_RRC: begin
          r8 = {a[0], a[7:1]};
          res.value = {8'h00, r8};
          res.flags = {cmd == CMD_RRC && r8 == 8'h00, 2'b00, a[0]};
        end
        CMD_RRA, CMD_RR: begin
          r8 = {cin, a[7:1]};
          res.value = {8'h00, r8};
          res.flags = {cmd == CMD_RR && r8 == 8'h00, 2'b00, a[0]};
        end
        CMD_DAA: begin
          // Corrections are chosen from the value before adjustment.
          r8 = a;
          cout = cin;
          if (!f[2]) begin
            if (cin || a > DAA_HI_LIMIT) begin
              r8 = r8 + DAA_HI_ADJ;
              cout = 1'b1;
            end
            if (f[1] || a[3:0] > DAA_LO_LIMIT) r8 = r8 + DAA_LO_ADJ;
          end else begin
            if (cin) r8 = r8 - DAA_HI_ADJ;
            if (f[1]) r8 = r8 - DAA_LO_ADJ;
          end
          res.value = {8'h00, r8};
          res.flags = {r8 == 8'h00, f[2], 1'b0, cout};
        end
        CMD_CPL: begin
          res.value = {8'h00, ~a};
          res.flags = {f[3], 1'b1, 1'b1, f[0]};
        end
        CMD_CCF, CMD_SCF: begin
          res.write_back = 1'b0;
          res.flags = {f[3], 2'b00, (cmd == CMD_SCF) ? 1'b1 : ~cin};
        end
        CMD_SLA, CMD_SRA, CMD_SRL: begin
          if (cmd == CMD_SLA) r8 = {a[6:0], 1'b0};
          else if (cmd == CMD_SRA) r8 = {a[7], a[7:1]};
          else r8 = {1'b0, a[7:1]};
          res.value = {8'h00, r8};
          res.flags = {r8 == 8'h00, 2'b00, (cmd == CMD_SLA) ? a[7] : a[0]};
        end
        CMD_SWAP: begin
          r8 = {a[3:0], a[7:4]};
          res.value = {8'h00, r8};
          res.flags = {r8 == 8'h00, 3'b000};
        end
        CMD_BIT: begin
          res.write_back = 1'b0;
          res.flags = {~a[bn], 1'b0, 1'b1, cin};
        end
        CMD_RES: res.value = {8'h00, a & ~(8'd1 << bn)};
        CMD_SET: res.value = {8'h00, a | (8'd1 << bn)};
        default: res.write_back = 1'b0;
      endcase
      return res;
    endfunction

    function void note_request(logic [5:0] cmd, logic [15:0] a16, logic [15:0] b16,
                               logic [3:0] f, logic [2:0] bn);
      pending_results.push_back(alu_predict(cmd, a16, b16, f, bn));
    endfunction

    task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      if (mismatches < 50) $display("MISMATCH %s: got %h, expected %h", what, got, want);
      mismatches++;
    endtask

    task check_result(logic [15:0] value, logic [3:0] flags, logic write_back);
      alu_out_t want;
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding", value, '0);
      end else begin
        want = pending_results.pop_front();
        if (value !== want.value) report_mismatch("result_value", value, want.value);
        if (flags !== want.flags) report_mismatch("flags_out", {12'h000, flags},
                                                  {12'h000, want.flags});
        if (write_back !== want.write_back) report_mismatch("write_back", {15'h0, write_back},
                                                            {15'h0, want.write_back});
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [5:0]  cmd_i = '0;
  logic [15:0] operand_a_i = '0;
  logic [15:0] operand_b_i = '0;
  logic [3:0]  flags_in_i = '0;
  logic [2:0]  bit_number_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] result_value_o;
  logic [3:0]  flags_out_o;
  logic        write_back_o;

  alu_check    results = new();
  bit          no_idle = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned quiet_cycles = 0;

  eight_bit_cpu_alu_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .flags_in_i    (flags_in_i),
    .bit_number_i  (bit_number_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_value_o(result_value_o),
    .flags_out_o   (flags_out_o),
    .write_back_o  (write_back_o)
  );

  always #10 clk_i = ~clk_i;

  // Result side: check every accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results.check_result(result_value_o, flags_out_o, write_back_o);
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Offers one request, starting and ending at a falling edge, and notes it once taken.
  task automatic send_request(logic [5:0] cmd, logic [15:0] a16, logic [15:0] b16,
                              logic [3:0] f, logic [2:0] bn);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    operand_a_i  <= a16;
    operand_b_i  <= b16;
    flags_in_i   <= f;
    bit_number_i <= bn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    results.note_request(cmd, a16, b16, f, bn);
    @(negedge clk_i);
  endtask

  // Operands lean towards the edges of the byte and word ranges.
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return {8'h00, 8'($urandom)};
      3: return {8'($urandom), 8'hFF};
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [5:0] cmd;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every operation once, with operands and flags varied by code.
    for (int c = 0; c <= CMD_SET; c++) begin
      send_request(6'(c), c[0] ? 16'hFFFF : 16'h0F80, c[1] ? 16'h00FF : 16'h0001,
                   4'(c), 3'(c));
    end
    // Carries out of the nibble and byte, borrow, decimal adjust both ways,
    // the bit-11 half carry, the most negative offset and an unused code.
    send_request(CMD_ADD, 16'h000F, 16'h0001, 4'b0000, 3'd0);
    send_request(CMD_ADC, 16'h00FF, 16'h0000, 4'b0001, 3'd0);
    send_request(CMD_SBC, 16'h0000, 16'h0000, 4'b0001, 3'd0);
    send_request(CMD_DAA, 16'h009A, 16'h0000, 4'b0000, 3'd0);
    send_request(CMD_DAA, 16'h0000, 16'h0000, 4'b0111, 3'd0);
    send_request(CMD_ADD16, 16'h0800, 16'h0800, 4'b1000, 3'd0);
    send_request(CMD_ADDSP, 16'hFFFF, 16'h0080, 4'b1111, 3'd0);
    send_request(CMD_BIT, 16'h0080, 16'h0000, 4'b0000, 3'd7);
    send_request(CMD_LAST_UNUSED, 16'hFFFF, 16'hFFFF, 4'b1111, 3'd7);

    // Random requests, with one stretch of no idling and one long result hold-off.
    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      no_idle = (i >= 300 && i < 500);
      if (i == 700) hold_off_req = 1'b1;
      if ($urandom_range(99) < 8) cmd = 6'($urandom_range(CMD_LAST_UNUSED, CMD_FIRST_UNUSED));
      else cmd = 6'($urandom_range(CMD_SET, CMD_ADD));
      send_request(cmd, pick_operand(), pick_operand(), 4'($urandom), 3'($urandom));
    end
    in_valid_i <= 1'b0;

    // Let the outstanding results drain and the pipeline settle, then report the verdict.
    while (results.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (results.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
